// ===== rtl/core/hip_pkg.sv =====
// hip_pkg: shared widths, CSR indexes and reset values for the
// Hilbert index to pixel core. No dependencies.
package hip_pkg;

   localparam int IDX_W     = 20;
   localparam int COORD_W   = 13;
   localparam int ORDER_W   = 4;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 13;

   localparam int DEFAULT_MAX_ORDER = 10;

   localparam logic [CSR_IDX_W-1:0] CSR_CURVE_ORDER   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_WIDTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_HEIGHT = 2'd2;

   localparam logic [ORDER_W-1:0] RESET_CURVE_ORDER   = 4'd3;
   localparam logic [COORD_W-1:0] RESET_WINDOW_WIDTH  = 13'd512;
   localparam logic [COORD_W-1:0] RESET_WINDOW_HEIGHT = 13'd512;

endpackage

// ===== rtl/core/hilbert_index_to_pixel_core.sv =====
// Hilbert curve index to pixel-center coordinate, four-stage pipeline.
// Depends on hip_pkg for widths, CSR indexes and reset values.
//
// Takes one request per clock unless back-pressure from rsp_ready stalls
// the pipe, and returns one response per request, in order. A request
// passes through four registers in order: the input register, the
// Hilbert cell walk, the two coordinate multipliers, and the offset add
// with the divide by 2^(order+1). A stage moves forward whenever the stage
// after it is empty or moving, so bubbles close up while rsp_ready is low
// and req_ready falls only once all four stages hold requests; with
// rsp_ready held high the sustained rate is one request per clock.
// Orders above MAX_ORDER saturate. Indexes at or beyond 4^order return
// rsp_in_range low with zero coordinates. CSRs may be written only when
// no request is in flight.
module hilbert_index_to_pixel_core #(
   parameter int MAX_ORDER = hip_pkg::DEFAULT_MAX_ORDER
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_write_enable,
   input  logic [hip_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [hip_pkg::CSR_DATA_W-1:0] csr_write_data,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [hip_pkg::IDX_W-1:0]      req_curve_index,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [hip_pkg::COORD_W-1:0]    rsp_pixel_x,
   output logic [hip_pkg::COORD_W-1:0]    rsp_pixel_y,
   output logic                           rsp_in_range
);

   localparam int IDX_W   = hip_pkg::IDX_W;
   localparam int COORD_W = hip_pkg::COORD_W;
   localparam int ORDER_W = hip_pkg::ORDER_W;
   localparam int OSW     = $clog2(MAX_ORDER + 1);
   localparam int CW      = MAX_ORDER;
   localparam int PAD_W   = IDX_W + 2 * MAX_ORDER;
   localparam int PW      = COORD_W + MAX_ORDER + 1;
   localparam int NW      = COORD_W + MAX_ORDER + 2;

   // configuration
   logic [ORDER_W-1:0] curve_order_ff;
   logic [COORD_W-1:0] window_width_ff;
   logic [COORD_W-1:0] window_height_ff;
   logic [OSW-1:0]     order_sat;
   logic [COORD_W-1:0] side;
   logic [COORD_W-1:0] diff_x;
   logic [COORD_W-1:0] diff_y;

   // stage valids and advance terms
   logic v1_ff, v2_ff, v3_ff, rsp_valid_ff;
   logic take1, take2, take3, take4;

   // stage 1: input register
   logic [IDX_W-1:0] idx_ff;
   logic [PAD_W-1:0] idx_pad;

   // stage 2: cell
   logic [CW-1:0] cell_a_in, cell_b_in;
   logic [CW-1:0] cell_a_ff, cell_b_ff;
   logic          in_range_in, in_range2_ff;

   // stage 3: products
   logic [PW-1:0] prod_x_in, prod_y_in;
   logic [PW-1:0] prod_x_ff, prod_y_ff;
   logic          in_range3_ff;

   // stage 4: result
   logic [NW-1:0]      num_x, num_y;
   logic [NW-1:0]      shr_x, shr_y;
   logic [COORD_W-1:0] pixel_x_in, pixel_y_in;
   logic [COORD_W-1:0] pixel_x_ff, pixel_y_ff;
   logic               in_range_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         curve_order_ff   <= hip_pkg::RESET_CURVE_ORDER;
         window_width_ff  <= hip_pkg::RESET_WINDOW_WIDTH;
         window_height_ff <= hip_pkg::RESET_WINDOW_HEIGHT;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            hip_pkg::CSR_CURVE_ORDER: begin
               curve_order_ff <= csr_write_data[ORDER_W-1:0];
            end
            hip_pkg::CSR_WINDOW_WIDTH: begin
               window_width_ff <= csr_write_data[COORD_W-1:0];
            end
            hip_pkg::CSR_WINDOW_HEIGHT: begin
               window_height_ff <= csr_write_data[COORD_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign order_sat = (curve_order_ff > ORDER_W'(MAX_ORDER)) ? OSW'(MAX_ORDER)
                                                             : OSW'(curve_order_ff);
   assign side   = (window_width_ff < window_height_ff) ? window_width_ff
                                                        : window_height_ff;
   assign diff_x = window_width_ff - side;
   assign diff_y = window_height_ff - side;

   // pipeline flow control
   assign take4     = !rsp_valid_ff || rsp_ready;
   assign take3     = !v3_ff || take4;
   assign take2     = !v2_ff || take3;
   assign take1     = !v1_ff || take2;
   assign req_ready = take1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (take1) v1_ff <= req_valid;
         if (take2) v2_ff <= v1_ff;
         if (take3) v3_ff <= v2_ff;
         if (take4) rsp_valid_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (take1) idx_ff <= req_curve_index;
   end

   assign idx_pad = {{(2 * MAX_ORDER){1'b0}}, idx_ff};

   // range check: no index bit at or above 2*order may be set
   always_comb begin
      in_range_in = 1'b1;
      for (int i = 0; i < IDX_W; i++) begin
         if ((i >= 2 * int'(order_sat)) && idx_ff[i]) in_range_in = 1'b0;
      end
   end

   // Hilbert walk, least significant digit first; x/y exchanged at the end
   always_comb begin : hilbert_walk
      logic [CW-1:0] a_v;
      logic [CW-1:0] b_v;
      logic [CW-1:0] tmp_v;
      logic [CW-1:0] mask_v;
      logic          rx;
      logic          ry;
      a_v    = '0;
      b_v    = '0;
      tmp_v  = '0;
      mask_v = '0;
      rx     = 1'b0;
      ry     = 1'b0;
      for (int k = 0; k < MAX_ORDER; k++) begin
         if (k < int'(order_sat)) begin
            rx     = idx_pad[2 * k + 1];
            ry     = idx_pad[2 * k] ^ rx;
            mask_v = ~({CW{1'b1}} << k);
            if (!ry) begin
               if (rx) begin
                  a_v = a_v ^ mask_v;
                  b_v = b_v ^ mask_v;
               end
               tmp_v = a_v;
               a_v   = b_v;
               b_v   = tmp_v;
            end
            a_v[k] = rx;
            b_v[k] = ry;
         end
      end
      cell_a_in = a_v;
      cell_b_in = b_v;
   end

   always_ff @(posedge clock) begin
      if (take2) begin
         cell_a_ff    <= cell_a_in;
         cell_b_ff    <= cell_b_in;
         in_range2_ff <= in_range_in;
      end
   end

   // (2c+1)*s; column b drives x, row a drives y
   assign prod_x_in = PW'({cell_b_ff, 1'b1}) * PW'(side);
   assign prod_y_in = PW'({cell_a_ff, 1'b1}) * PW'(side);

   always_ff @(posedge clock) begin
      if (take3) begin
         prod_x_ff    <= prod_x_in;
         prod_y_ff    <= prod_y_in;
         in_range3_ff <= in_range2_ff;
      end
   end

   // ((w-s)*n + (2c+1)*s) / (2n)
   assign num_x = (NW'(diff_x) << order_sat) + NW'(prod_x_ff);
   assign num_y = (NW'(diff_y) << order_sat) + NW'(prod_y_ff);
   assign shr_x = num_x >> order_sat;
   assign shr_y = num_y >> order_sat;
   assign pixel_x_in = in_range3_ff ? shr_x[COORD_W:1] : '0;
   assign pixel_y_in = in_range3_ff ? shr_y[COORD_W:1] : '0;

   always_ff @(posedge clock) begin
      if (take4) begin
         pixel_x_ff  <= pixel_x_in;
         pixel_y_ff  <= pixel_y_in;
         in_range_ff <= in_range3_ff;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_pixel_x  = pixel_x_ff;
   assign rsp_pixel_y  = pixel_y_ff;
   assign rsp_in_range = in_range_ff;

`ifndef SYNTHESIS
   a_out_of_range_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !in_range_ff |-> (pixel_x_ff == '0) && (pixel_y_ff == '0))
      else $error("out-of-range response carries nonzero coordinates");

   a_center_inside_window: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && in_range_ff |->
         ((pixel_x_ff < window_width_ff) || (window_width_ff == '0)) &&
         ((pixel_y_ff < window_height_ff) || (window_height_ff == '0)))
      else $error("cell center lies outside the window");

   a_cell_within_grid: assert property (@(posedge clock) disable iff (reset)
      v2_ff && in_range2_ff |->
         ((cell_a_ff >> order_sat) == '0) && ((cell_b_ff >> order_sat) == '0))
      else $error("cell coordinate exceeds grid side");

   a_stall_holds_pipe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready && v3_ff |=> v3_ff && $stable(prod_x_ff))
      else $error("product stage changed while output stalled");
`endif

endmodule

// ===== bench/hilbert_index_to_pixel_core_tb.sv =====
`timescale 1ns / 100ps
// Testbench for hilbert_index_to_pixel_core: directed and random curve indexes under
// several CSR settings, each response checked against an in-bench Hilbert-to-pixel predictor.
// Depends on hip_pkg and the core RTL.

typedef struct packed {
   logic [hip_pkg::COORD_W-1:0] x;
   logic [hip_pkg::COORD_W-1:0] y;
   logic                        in_range;
} pixel_point_type;

class hilbert_pixel_checker;
   logic [hip_pkg::ORDER_W-1:0] curve_order;
   logic [hip_pkg::COORD_W-1:0] window_width;
   logic [hip_pkg::COORD_W-1:0] window_height;
   pixel_point_type             pending_pixels[$];
   int                          mismatches;

   function new();
      curve_order   = hip_pkg::RESET_CURVE_ORDER;
      window_width  = hip_pkg::RESET_WINDOW_WIDTH;
      window_height = hip_pkg::RESET_WINDOW_HEIGHT;
      mismatches    = 0;
   endfunction

   function void set_register(logic [hip_pkg::CSR_IDX_W-1:0] index,
                              logic [hip_pkg::CSR_DATA_W-1:0] data);
      case (index)
         hip_pkg::CSR_CURVE_ORDER:   curve_order   = data[hip_pkg::ORDER_W-1:0];
         hip_pkg::CSR_WINDOW_WIDTH:  window_width  = data[hip_pkg::COORD_W-1:0];
         hip_pkg::CSR_WINDOW_HEIGHT: window_height = data[hip_pkg::COORD_W-1:0];
         default: ;
      endcase
   endfunction

   function int pending();
      return pending_pixels.size();
   endfunction

   // truncated center of cell c on an axis of extent w, square side s, n cells
   function logic [hip_pkg::COORD_W-1:0] cell_center(longint unsigned w, longint unsigned s,
                                                     longint unsigned n, longint unsigned c);
      longint unsigned q;
      q = ((w - s) * n + (64'd2 * c + 64'd1) * s) / (64'd2 * n);
      return q[hip_pkg::COORD_W-1:0];
   endfunction

   function void note_index(logic [hip_pkg::IDX_W-1:0] curve_index);
      pixel_point_type p;
      int unsigned     depth;
      longint unsigned cells, w, h, side, t, col, row, half, rx, ry, tmp;
      depth = (int'(curve_order) > hip_pkg::DEFAULT_MAX_ORDER) ?
              hip_pkg::DEFAULT_MAX_ORDER : int'(curve_order);
      cells = 64'd1 << depth;
      w     = 64'(window_width);
      h     = 64'(window_height);
      side  = (w < h) ? w : h;
      p     = '0;
      if (64'(curve_index) < cells * cells) begin
         t   = 64'(curve_index);
         col = 0;
         row = 0;
         for (int k = 0; k < int'(depth); k++) begin
            half = 64'd1 << k;
            rx   = (t >> 1) & 64'd1;
            ry   = (t ^ rx) & 64'd1;
            if (ry == 0) begin
               if (rx == 1) begin
                  col = half - 1 - col;
                  row = half - 1 - row;
               end
               tmp = col;
               col = row;
               row = tmp;
            end
            col = col + half * rx;
            row = row + half * ry;
            t   = t >> 2;
         end
         // x and y roles exchanged
         p.x        = cell_center(w, side, cells, row);
         p.y        = cell_center(h, side, cells, col);
         p.in_range = 1'b1;
      end
      pending_pixels.push_back(p);
   endfunction

   function void check_pixel(logic [hip_pkg::COORD_W-1:0] x, logic [hip_pkg::COORD_W-1:0] y,
                             logic in_range);
      pixel_point_type want;
      if (pending_pixels.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected response: x=%0d y=%0d in_range=%0d", x, y, in_range);
         return;
      end
      want = pending_pixels.pop_front();
      if (x !== want.x || y !== want.y || in_range !== want.in_range) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch: expected x=%0d y=%0d in_range=%0d, got x=%0d y=%0d %s%0d",
                     want.x, want.y, want.in_range, x, y, "in_range=", in_range);
      end
   endfunction
endclass

module hilbert_index_to_pixel_core_tb;

   localparam int WATCHDOG_LIMIT  = 2000;
   localparam int HOLD_OFF_CYCLES = 200;
   localparam int RANDOM_PHASES   = 12;
   localparam int PHASE_REQUESTS  = 161;

   logic                           clock;
   logic                           reset;
   logic                           csr_write_enable;
   logic [hip_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [hip_pkg::CSR_DATA_W-1:0] csr_write_data;
   logic                           req_valid;
   logic                           req_ready;
   logic [hip_pkg::IDX_W-1:0]      req_curve_index;
   logic                           rsp_valid;
   logic                           rsp_ready;
   logic [hip_pkg::COORD_W-1:0]    rsp_pixel_x;
   logic [hip_pkg::COORD_W-1:0]    rsp_pixel_y;
   logic                           rsp_in_range;

   logic                           no_idle;
   logic                           hold_off_request;
   int                             watchdog_count;
   hilbert_pixel_checker           pixel_check;

   hilbert_index_to_pixel_core dut (
      .clock           (clock),
      .reset           (reset),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_curve_index (req_curve_index),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pixel_x     (rsp_pixel_x),
      .rsp_pixel_y     (rsp_pixel_y),
      .rsp_in_range    (rsp_in_range)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            pixel_check.note_index(req_curve_index);
         if (rsp_valid && rsp_ready)
            pixel_check.check_pixel(rsp_pixel_x, rsp_pixel_y, rsp_in_range);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         watchdog_count <= 0;
      end else if (watchdog_count >= WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         watchdog_count <= watchdog_count + 1;
      end
   end

   // response side: random back-pressure, plus one long hold-off on request
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else begin
            rsp_ready <= no_idle || ($urandom_range(99) >= 38);
         end
      end
   end

   task automatic send_index(input logic [hip_pkg::IDX_W-1:0] idx);
      while (!no_idle && $urandom_range(99) < 38) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_curve_index <= idx;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic drain_requests;
      req_valid <= 1'b0;
      do @(posedge clock); while (pixel_check.pending() != 0);
   endtask

   task automatic write_config(input logic [hip_pkg::CSR_DATA_W-1:0] order_data,
                               input logic [hip_pkg::COORD_W-1:0] width,
                               input logic [hip_pkg::COORD_W-1:0] height);
      csr_write_enable <= 1'b1;
      csr_index        <= hip_pkg::CSR_CURVE_ORDER;
      csr_write_data   <= order_data;
      @(posedge clock);
      csr_index      <= hip_pkg::CSR_WINDOW_WIDTH;
      csr_write_data <= width;
      @(posedge clock);
      csr_index      <= hip_pkg::CSR_WINDOW_HEIGHT;
      csr_write_data <= height;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      pixel_check.set_register(hip_pkg::CSR_CURVE_ORDER, order_data);
      pixel_check.set_register(hip_pkg::CSR_WINDOW_WIDTH, width);
      pixel_check.set_register(hip_pkg::CSR_WINDOW_HEIGHT, height);
   endtask

   function automatic logic [hip_pkg::COORD_W-1:0] pick_extent();
      case ($urandom_range(7))
         0:       return '0;
         1:       return 13'd8191;
         2:       return 13'd1;
         3, 4:    return hip_pkg::COORD_W'($urandom_range(1, 64));
         default: return hip_pkg::COORD_W'($urandom_range(1, 8191));
      endcase
   endfunction

   initial begin
      logic [hip_pkg::ORDER_W-1:0] order;
      int                          depth;
      logic [hip_pkg::IDX_W-1:0]   idx;
      pixel_check      = new();
      reset            = 1'b1;
      csr_write_enable = 1'b0;
      csr_index        = hip_pkg::CSR_CURVE_ORDER;
      csr_write_data   = '0;
      req_valid        = 1'b0;
      req_curve_index  = '0;
      no_idle          = 1'b0;
      hold_off_request = 1'b0;
      watchdog_count   = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset settings: order 3, 512 x 512
      send_index(20'd0);
      send_index(20'd1);
      send_index(20'd2);
      send_index(20'd3);
      send_index(20'd63);
      send_index(20'd64);
      send_index(20'hFFFFF);
      send_index(20'h55555);
      send_index(20'hAAAAA);
      drain_requests;

      // single cell, wide and flat window
      write_config(13'd0, 13'd8191, 13'd1);
      send_index(20'd0);
      send_index(20'd1);
      send_index(20'hFFFFF);
      drain_requests;

      // order saturates, zero width
      write_config(13'h1FFF, 13'd0, 13'd8191);
      send_index(20'd0);
      send_index(20'hFFFFF);
      send_index(20'h80000);
      drain_requests;

      write_config(13'd10, 13'd8191, 13'd8191);
      send_index(20'd0);
      send_index(20'hFFFFF);
      send_index(20'h7FFFF);
      drain_requests;

      write_config(13'd11, 13'd1, 13'd0);
      send_index(20'd0);
      send_index(20'd5);
      drain_requests;

      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         order = hip_pkg::ORDER_W'($urandom_range(15));
         write_config({9'($urandom), order}, pick_extent(), pick_extent());
         depth = (int'(order) > hip_pkg::DEFAULT_MAX_ORDER) ?
                 hip_pkg::DEFAULT_MAX_ORDER : int'(order);
         no_idle = (ph == 0);
         for (int i = 0; i < PHASE_REQUESTS; i++) begin
            if ($urandom_range(99) < 80)
               idx = hip_pkg::IDX_W'($urandom_range(0, (1 << (2 * depth)) - 1));
            else
               idx = hip_pkg::IDX_W'($urandom);
            send_index(idx);
            if (ph == 1 && i == 30)
               hold_off_request = 1'b1;
         end
         drain_requests;
      end
      no_idle = 1'b0;

      repeat (10) @(posedge clock);
      if (pixel_check.mismatches == 0 && pixel_check.pending() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
